// ----- rtl/accent_folded_substring_search_macros.svh -----
// Assertion macros shared by the accent folded search RTL
`ifndef ACCENT_FOLDED_SUBSTRING_SEARCH_MACROS_SVH
`define ACCENT_FOLDED_SUBSTRING_SEARCH_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst
`define AFSS_ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst
`define AFSS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/afss_pkg.sv -----
// Package: constants, queue item type and folding functions for the search block
`timescale 1ns / 1ps

package afss_pkg;

  localparam int PATTERN_MAX_DEFAULT   = 16;
  localparam int POSITION_BITS_DEFAULT = 24;

  localparam int PATTERN_CHARS  = 16;
  localparam int LENGTH_BITS    = 5;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 64;
  localparam int RESULT_SLOTS   = 3;
  localparam int SLOT_BITS      = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 2'd2;

  localparam logic [7:0] LEAD_BYTE    = 8'hC3;
  localparam logic [7:0] ACCENT_FIRST = 8'h80;
  localparam logic [7:0] ACCENT_LAST  = 8'hBD;
  localparam logic [7:0] ACCENT_LOWER = 8'hA0;
  localparam logic [7:0] A_RING_LAST  = 8'h85;
  localparam logic [7:0] C_CEDILLA    = 8'h87;
  localparam logic [7:0] N_TILDE      = 8'h91;
  localparam logic [7:0] Y_ACUTE      = 8'h9D;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;
  localparam logic [7:0] UPPER_A      = 8'h41;
  localparam logic [7:0] UPPER_Z      = 8'h5A;
  localparam logic [7:0] NO_MAPPING   = 8'h00;

  typedef struct packed {
    logic [7:0] c0;
    logic       v0;
    logic [7:0] c1;
    logic       v1;
    logic       fin;
  } entry_t;

  function automatic logic [7:0] fold_accent(input logic [7:0] b);
    logic [7:0] u;
    logic [7:0] r;
    u = (b >= ACCENT_LOWER) ? b - CASE_OFFSET : b;
    r = NO_MAPPING;
    if (b >= ACCENT_FIRST && b <= ACCENT_LAST) begin
      if (u <= A_RING_LAST) r = 8'h61;
      else if (u == C_CEDILLA) r = 8'h63;
      else if (u >= 8'h88 && u <= 8'h8B) r = 8'h65;
      else if (u >= 8'h8C && u <= 8'h8F) r = 8'h69;
      else if (u == N_TILDE) r = 8'h6E;
      else if (u >= 8'h92 && u <= 8'h96) r = 8'h6F;
      else if (u >= 8'h99 && u <= 8'h9C) r = 8'h75;
      else if (u == Y_ACUTE) r = 8'h79;
    end
    return r;
  endfunction

  function automatic logic [7:0] fold_plain(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= UPPER_A && b <= UPPER_Z) r = b + CASE_OFFSET;
    return r;
  endfunction

endpackage

// ----- rtl/accent_folded_substring_search.sv -----
// Top level: accent folded substring search, front end, queue and matcher
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------------------------
//   text     | text_valid / text_stall  | text_byte, final_byte
//   result   | result_valid / result_stall | match_position, end_marker, last_result
//   cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One text byte per cycle while text_stall is low; an item that yields several
// results holds the output register until each result is taken, while the queue
// absorbs the difference. A byte passes a queue slot, then the result register.
// Reset is synchronous on rst; pattern registers read zero, matching is off.
// result_stall backs up into a four-item queue; text_stall rises when it is full.
`timescale 1ns / 1ps

module accent_folded_substring_search #(
  parameter int PATTERN_MAX   = afss_pkg::PATTERN_MAX_DEFAULT,
  parameter int POSITION_BITS = afss_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                text_valid,
  output logic                                text_stall,
  input  logic [7:0]                          text_byte,
  input  logic                                final_byte,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [POSITION_BITS-1:0]            match_position,
  output logic                                end_marker,
  output logic                                last_result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [afss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [afss_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  logic             push;
  logic             full;
  logic             pop;
  logic             q_valid;
  afss_pkg::entry_t push_entry;
  afss_pkg::entry_t pop_entry;

  assign cfg_ready = 1'b1;

  afss_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .full       (full),
    .push       (push),
    .entry      (push_entry)
  );

  afss_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .valid      (q_valid),
    .pop_entry  (pop_entry)
  );

  afss_back #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .valid          (q_valid),
    .entry          (pop_entry),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .match_position (match_position),
    .end_marker     (end_marker),
    .last_result    (last_result)
  );

endmodule

// ----- rtl/afss_front.sv -----
// Front end: takes raw bytes, folds them into up to two characters plus an end flag
`timescale 1ns / 1ps

module afss_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             text_valid,
  output logic             text_stall,
  input  logic [7:0]       text_byte,
  input  logic             final_byte,
  input  logic             full,
  output logic             push,
  output afss_pkg::entry_t entry
);

  logic       pending;
  logic       pending_next;
  logic       accept;
  logic [7:0] mapped;
  logic [7:0] plain;
  logic       is_lead;

  assign text_stall = full;
  assign accept     = text_valid && !full;
  assign mapped     = afss_pkg::fold_accent(text_byte);
  assign plain      = afss_pkg::fold_plain(text_byte);
  assign is_lead    = (text_byte == afss_pkg::LEAD_BYTE);

  always_comb begin
    entry        = '0;
    pending_next = pending;
    if (pending) begin
      if (mapped != afss_pkg::NO_MAPPING) begin
        entry.c0     = mapped;
        entry.v0     = 1'b1;
        pending_next = 1'b0;
      end else begin
        entry.c0 = afss_pkg::LEAD_BYTE;
        entry.v0 = 1'b1;
        if (is_lead) begin
          pending_next = 1'b1;
        end else begin
          entry.c1     = plain;
          entry.v1     = 1'b1;
          pending_next = 1'b0;
        end
      end
    end else if (is_lead) begin
      pending_next = 1'b1;
    end else begin
      entry.c0 = plain;
      entry.v0 = 1'b1;
    end
    // flush a dangling lead before the end marker
    if (final_byte) begin
      if (pending_next) begin
        if (entry.v0) begin
          entry.c1 = afss_pkg::LEAD_BYTE;
          entry.v1 = 1'b1;
        end else begin
          entry.c0 = afss_pkg::LEAD_BYTE;
          entry.v0 = 1'b1;
        end
      end
      entry.fin    = 1'b1;
      pending_next = 1'b0;
    end
  end

  assign push = accept && (entry.v0 || entry.fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (accept) begin
      pending <= pending_next;
    end
  end

endmodule

// ----- rtl/afss_fifo.sv -----
// Short queue of folded items between the front end and the matcher
`timescale 1ns / 1ps

`include "accent_folded_substring_search_macros.svh"

module afss_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  afss_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output afss_pkg::entry_t pop_entry
);

  localparam logic [afss_pkg::QPTR_BITS-1:0] LAST_SLOT =
    afss_pkg::QPTR_BITS'(afss_pkg::QUEUE_DEPTH - 1);
  localparam logic [afss_pkg::QCOUNT_BITS-1:0] FULL_COUNT =
    afss_pkg::QCOUNT_BITS'(afss_pkg::QUEUE_DEPTH);

  afss_pkg::entry_t                   slots [afss_pkg::QUEUE_DEPTH];
  logic [afss_pkg::QPTR_BITS-1:0]     wr_ptr;
  logic [afss_pkg::QPTR_BITS-1:0]     rd_ptr;
  logic [afss_pkg::QCOUNT_BITS-1:0]   count;
  logic                               do_push;
  logic                               do_pop;

  assign full      = (count == FULL_COUNT);
  assign valid     = (count != '0);
  assign pop_entry = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `AFSS_ASSERT_IMPLY(a_no_push_when_full, push, !full, "item pushed into a full queue")
  `AFSS_ASSERT_NEXT(a_count_grows, do_push && !do_pop, count == $past(count) + 1'b1, "queue count did not grow")

endmodule

// ----- rtl/afss_back.sv -----
// Back end: pattern registers, character window, match check and result sequencing
`timescale 1ns / 1ps

`include "accent_folded_substring_search_macros.svh"

module afss_back #(
  parameter int PATTERN_MAX   = afss_pkg::PATTERN_MAX_DEFAULT,
  parameter int POSITION_BITS = afss_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [afss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [afss_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                valid,
  input  afss_pkg::entry_t                    entry,
  output logic                                pop,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [POSITION_BITS-1:0]            match_position,
  output logic                                end_marker,
  output logic                                last_result
);

  localparam int CMP = (PATTERN_MAX < afss_pkg::PATTERN_CHARS) ?
                       PATTERN_MAX : afss_pkg::PATTERN_CHARS;
  localparam int LB  = afss_pkg::LENGTH_BITS;
  localparam logic [LB-1:0] CMP_LEN = LB'(CMP);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  typedef logic [PATTERN_MAX-1:0][7:0] window_t;
  typedef logic [CMP-1:0][7:0]         aligned_t;
  typedef logic [POSITION_BITS-1:0]    pos_t;

  logic [afss_pkg::CFG_DATA_BITS-1:0] pattern_low;
  logic [afss_pkg::CFG_DATA_BITS-1:0] pattern_high;
  logic [LB-1:0]                      pattern_length;
  aligned_t                           pat_al;
  aligned_t                           pat_al_next;
  logic [LB-1:0]                      len_act;
  logic [LB-1:0]                      len_next;

  window_t       window;
  pos_t          folded_count;
  logic [LB-1:0] gap_count;

  pos_t                          res_pos [afss_pkg::RESULT_SLOTS];
  logic [afss_pkg::RESULT_SLOTS-1:0] res_end;
  logic [afss_pkg::SLOT_BITS-1:0]    res_cnt;
  logic [afss_pkg::SLOT_BITS-1:0]    res_idx;

  pos_t                          n_pos [afss_pkg::RESULT_SLOTS];
  logic [afss_pkg::RESULT_SLOTS-1:0] n_end;
  logic [afss_pkg::SLOT_BITS-1:0]    n_cnt;
  logic [afss_pkg::SLOT_BITS-1:0]    hit_cnt;

  window_t       win1;
  window_t       win2;
  pos_t          len_ext;
  pos_t          count1;
  pos_t          count2;
  pos_t          pos0;
  pos_t          pos1;
  logic [LB-1:0] gap_dec0;
  logic [LB-1:0] gap_dec1;
  logic [LB-1:0] gap1;
  logic [LB-1:0] gap2;
  logic          hit0;
  logic          hit1;
  logic          result_fire;
  logic [2*afss_pkg::CFG_DATA_BITS-1:0] pat_all;

  function automatic window_t shift_in(input window_t w, input logic [7:0] c);
    window_t r;
    r[0] = c;
    for (int i = 1; i < PATTERN_MAX; i++) r[i] = w[i-1];
    return r;
  endfunction

  function automatic logic window_hit(input window_t w, input aligned_t p,
                                      input logic [LB-1:0] len);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < CMP; i++) begin
      if (LB'(i) < len && w[i] != p[i]) ok = 1'b0;
    end
    return ok;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        afss_pkg::REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        afss_pkg::REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        afss_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[LB-1:0];
        default: ;
      endcase
    end
  end

  // reverse the pattern so that entry i lines up with window entry i
  always_comb begin
    logic [3:0] k;
    pat_all  = {pattern_high, pattern_low};
    len_next = (pattern_length > CMP_LEN) ? CMP_LEN : pattern_length;
    for (int i = 0; i < CMP; i++) begin
      k = 4'(len_next - LB'(1) - LB'(i));
      pat_al_next[i] = (LB'(i) < len_next) ? pat_all[{k, 3'b000} +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_act <= '0;
    end else begin
      len_act <= len_next;
    end
    pat_al <= pat_al_next;
  end

  // two chained character pushes per item
  always_comb begin
    len_ext  = POSITION_BITS'(len_act);
    win1     = shift_in(window, entry.c0);
    win2     = shift_in(win1, entry.c1);
    gap_dec0 = (gap_count != '0) ? gap_count - 1'b1 : '0;
    hit0     = entry.v0 && (len_act != '0) && (gap_dec0 == '0) &&
               (folded_count >= len_ext - 1'b1) && window_hit(win1, pat_al, len_act);
    pos0     = folded_count - (len_ext - 1'b1);
    count1   = (folded_count == POS_MAX) ? folded_count : folded_count + 1'b1;
    gap1     = hit0 ? len_act : gap_dec0;
    gap_dec1 = (gap1 != '0) ? gap1 - 1'b1 : '0;
    hit1     = entry.v1 && (len_act != '0) && (gap_dec1 == '0) &&
               (count1 >= len_ext - 1'b1) && window_hit(win2, pat_al, len_act);
    pos1     = count1 - (len_ext - 1'b1);
    count2   = (count1 == POS_MAX) ? count1 : count1 + 1'b1;
    gap2     = hit1 ? len_act : gap_dec1;

    hit_cnt  = afss_pkg::SLOT_BITS'(hit0) + afss_pkg::SLOT_BITS'(hit1);
    n_pos[0] = hit0 ? pos0 : (hit1 ? pos1 : '0);
    n_pos[1] = (hit0 && hit1) ? pos1 : '0;
    n_pos[2] = '0;
    for (int s = 0; s < afss_pkg::RESULT_SLOTS; s++) begin
      n_end[s] = entry.fin && (hit_cnt == afss_pkg::SLOT_BITS'(s));
    end
    n_cnt = hit_cnt + afss_pkg::SLOT_BITS'(entry.fin);
  end

  assign result_valid   = (res_idx != res_cnt);
  assign result_fire    = result_valid && !result_stall;
  assign last_result    = (res_idx == res_cnt - 1'b1);
  assign match_position = res_pos[res_idx];
  assign end_marker     = res_end[res_idx];
  assign pop            = valid && (!result_valid || (result_fire && last_result));

  always_ff @(posedge clk) begin
    if (rst) begin
      folded_count <= '0;
      gap_count    <= '0;
      res_cnt      <= '0;
      res_idx      <= '0;
    end else if (pop) begin
      res_cnt <= n_cnt;
      res_idx <= '0;
      if (entry.fin) begin
        folded_count <= '0;
        gap_count    <= '0;
      end else if (entry.v1) begin
        folded_count <= count2;
        gap_count    <= gap2;
      end else if (entry.v0) begin
        folded_count <= count1;
        gap_count    <= gap1;
      end
    end else if (result_fire) begin
      res_idx <= res_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_pos <= n_pos;
      res_end <= n_end;
      if (entry.v1) begin
        window <= win2;
      end else if (entry.v0) begin
        window <= win1;
      end
    end
  end

  `AFSS_ASSERT_NEXT(a_end_clears_run, pop && entry.fin, folded_count == '0 && gap_count == '0, "run state not cleared after end")
  `AFSS_ASSERT_IMPLY(a_end_is_last, result_valid && end_marker, last_result && match_position == '0, "end marker not last or nonzero")
  `AFSS_ASSERT_IMPLY(a_hold_pending_results, result_valid && !last_result, !pop, "new item loaded over pending results")

endmodule
